[rtl/rd32_pkg.sv]
package rd32_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int STAGES     = DATA_WIDTH;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } t_out;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] part;
        logic [DATA_WIDTH-1:0] qd;
        logic [DATA_WIDTH-1:0] den;
    } t_stage;

endpackage

[rtl/rd32_cell.sv]
module rd32_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_en,
    input  rd32_pkg::t_stage i_stage,
    output logic            o_valid,
    output rd32_pkg::t_stage o_stage
);

    logic                          r_valid;
    rd32_pkg::t_stage              r_stage;
    rd32_pkg::t_stage              n_stage;
    logic [rd32_pkg::DATA_WIDTH-1:0] shifted;
    logic [rd32_pkg::DATA_WIDTH:0]   diff;
    logic                          ge;

    always_comb begin
        shifted = {i_stage.part[rd32_pkg::DATA_WIDTH-2:0],
                   i_stage.qd[rd32_pkg::DATA_WIDTH-1]};
        diff    = {i_stage.part[rd32_pkg::DATA_WIDTH-1], shifted}
                - {1'b0, i_stage.den};
        ge      = ~diff[rd32_pkg::DATA_WIDTH];
        n_stage.part = ge ? diff[rd32_pkg::DATA_WIDTH-1:0] : shifted;
        n_stage.qd   = {i_stage.qd[rd32_pkg::DATA_WIDTH-2:0], ge};
        n_stage.den  = i_stage.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/restoring_divider_32.sv]
// Unsigned 32-bit restoring divider, one restoring step per pipeline cell.
// Input channel: i_valid, i_in (dividend, divisor), o_stall. An item is
// taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid, o_out (quotient, remainder), i_stall. An item
// leaves at a rising edge where o_valid is high and i_stall is low.
// The pipeline has 32 cells, and each registers the result of its restoring
// step; the result leaves from the last cell. Throughput is one item per
// cycle while the receiver does not stall.
// A zero divisor gives an all-ones quotient and the dividend as remainder.
// When the receiver stalls, the last cell holds its item; empty cells ahead
// of it keep filling, so input is refused only once every cell between the
// input and the stalled output holds an item.
// Reset (synchronous, active low) empties every cell; items in flight are
// dropped and o_valid is low in the cycle after reset.
module restoring_divider_32 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rd32_pkg::t_in i_in,
    output logic          o_stall,
    output logic          o_valid,
    output rd32_pkg::t_out o_out,
    input  logic          i_stall
);

    logic [rd32_pkg::STAGES-1:0] w_valid;
    logic [rd32_pkg::STAGES:0]   w_en;
    rd32_pkg::t_stage            w_stage [rd32_pkg::STAGES];
    rd32_pkg::t_stage            w_first;

    assign w_first.part = '0;
    assign w_first.qd   = i_in.dividend;
    assign w_first.den  = i_in.divisor;

    assign w_en[rd32_pkg::STAGES] = ~i_stall;

    genvar k;
    generate
        for (k = 0; k < rd32_pkg::STAGES; k++) begin : g_cell
            assign w_en[k] = ~w_valid[k] | w_en[k+1];
            if (k == 0) begin : g_head
                rd32_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (i_valid),
                    .i_en    (w_en[k]),
                    .i_stage (w_first),
                    .o_valid (w_valid[k]),
                    .o_stage (w_stage[k])
                );
            end else begin : g_body
                rd32_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (w_valid[k-1]),
                    .i_en    (w_en[k]),
                    .i_stage (w_stage[k-1]),
                    .o_valid (w_valid[k]),
                    .o_stage (w_stage[k])
                );
            end
        end
    endgenerate

    assign o_stall         = ~w_en[0];
    assign o_valid         = w_valid[rd32_pkg::STAGES-1];
    assign o_out.quotient  = w_stage[rd32_pkg::STAGES-1].qd;
    assign o_out.remainder = w_stage[rd32_pkg::STAGES-1].part;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_valid && i_stall) |-> o_stall)
        else $error("full pipeline with stalled output still accepts");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_stage[rd32_pkg::STAGES-1].den != '0)
        |-> (o_out.remainder < w_stage[rd32_pkg::STAGES-1].den))
        else $error("remainder not below divisor");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_stage[rd32_pkg::STAGES-1].den == '0)
        |-> (o_out.quotient == '1))
        else $error("zero divisor quotient not all ones");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_valid == '0))
        else $error("cells not empty after reset");

endmodule

[verif/restoring_divider_32_checker.sv]
module restoring_divider_32_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rd32_pkg::t_in  i_in_item,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  rd32_pkg::t_out i_out_item,
    input  logic           i_out_stall,
    output int             o_pending,
    output int             o_fail_count
);

    rd32_pkg::t_out owed_results[$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic rd32_pkg::t_out divide_unsigned(rd32_pkg::t_in op);
        logic [rd32_pkg::DATA_WIDTH:0]   partial;
        logic [rd32_pkg::DATA_WIDTH-1:0] quo;
        rd32_pkg::t_out                  res;
        partial = '0;
        quo     = '0;
        for (int k = rd32_pkg::DATA_WIDTH - 1; k >= 0; k--) begin
            partial = {partial[rd32_pkg::DATA_WIDTH-1:0], op.dividend[k]};
            if (partial >= {1'b0, op.divisor}) begin
                partial = partial - {1'b0, op.divisor};
                quo[k]  = 1'b1;
            end
        end
        res.quotient  = quo;
        res.remainder = partial[rd32_pkg::DATA_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [rd32_pkg::DATA_WIDTH-1:0] want,
                                   input logic [rd32_pkg::DATA_WIDTH-1:0] got);
        $display("MISMATCH %s: expected %h, got %h", what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        rd32_pkg::t_out want;
        if (!i_rst_n) begin
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected item, quotient", '0, i_out_item.quotient);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_item.quotient !== want.quotient)
                        report_mismatch("quotient", want.quotient, i_out_item.quotient);
                    if (i_out_item.remainder !== want.remainder)
                        report_mismatch("remainder", want.remainder, i_out_item.remainder);
                end
            end
            if (i_in_valid && !i_in_stall)
                owed_results.push_back(divide_unsigned(i_in_item));
        end
        o_pending <= owed_results.size();
    end

endmodule

[verif/restoring_divider_32_tb.sv]
module restoring_divider_32_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 4;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    rd32_pkg::t_in  i_in    = '0;
    logic           i_stall = 1'b0;
    logic           o_stall;
    logic           o_valid;
    rd32_pkg::t_out o_out;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    restoring_divider_32 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    restoring_divider_32_checker division_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_item    (i_in),
        .i_in_stall   (o_stall),
        .i_out_valid  (o_valid),
        .i_out_item   (o_out),
        .i_out_stall  (i_stall),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [rd32_pkg::DATA_WIDTH-1:0] pick_operand();
        logic [rd32_pkg::DATA_WIDTH-1:0] val;
        case ($urandom_range(7))
            0:       val = '0;
            1:       val = '1;
            2:       val = 32'h1 << $urandom_range(rd32_pkg::DATA_WIDTH - 1);
            3, 4:    val = $urandom >> $urandom_range(rd32_pkg::DATA_WIDTH - 1);
            default: val = $urandom;
        endcase
        return val;
    endfunction

    task automatic send_division(input rd32_pkg::t_in op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= op;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    rd32_pkg::t_in directed_ops[] = '{
        '{32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000},
        '{32'h0000_0005, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001},
        '{32'h0000_0000, 32'h0000_0001},
        '{32'h8000_0000, 32'h0000_0001},
        '{32'hFFFF_FFFF, 32'h0000_0002},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE},
        '{32'h8000_0000, 32'h8000_0000},
        '{32'h7FFF_FFFF, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'h8000_0001},
        '{32'h0000_0001, 32'hFFFF_FFFF},
        '{32'h1234_5678, 32'h0000_0001},
        '{32'hDEAD_BEEF, 32'h0001_0000},
        '{32'h0000_0001, 32'h0000_0001}
    };

    initial begin
        rd32_pkg::t_in op;
        int            idle_sets[PHASES][2];
        idle_sets = '{'{0, 0}, '{80, 0}, '{0, 80}, '{12, 12}};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[k])
            send_division(directed_ops[k]);

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = idle_sets[p][0];
            stall_pct     = idle_sets[p][1];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                op.dividend = pick_operand();
                op.divisor  = pick_operand();
                send_division(op);
            end
        end

        i_valid   <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
